// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/msa_pkg.sv
// ---------------------------------------------------------------------------
// msa_pkg
// Word types and codes for the modular signed ALU.
// ---------------------------------------------------------------------------
package msa_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_REM = 4'd4;
	localparam logic [3:0] OP_GTH = 4'd5;
	localparam logic [3:0] OP_LTH = 4'd6;
	localparam logic [3:0] OP_LTE = 4'd7;
	localparam logic [3:0] OP_GTE = 4'd8;
	localparam logic [3:0] OP_NEG = 4'd9;
	localparam logic [3:0] OP_ABS = 4'd10;
	localparam logic [3:0] OP_POW = 4'd11;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_WIDE = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	localparam logic [1:0] MAC_LAST = 2'd2;

	typedef struct packed {
		logic [3:0]  operation;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic [63:0] value;
		logic        compare_true;
		logic [1:0]  status;
	} out_word_t;

endpackage

// File: rtl/core/msa_mac.sv
// ---------------------------------------------------------------------------
// msa_mac
// One step of a 64x64 low-half product built from 32x32 partial products.
// ---------------------------------------------------------------------------
module msa_mac (
	input  logic [63:0] x,
	input  logic [63:0] y,
	input  logic [1:0]  step,
	input  logic [63:0] acc,
	output logic [63:0] sum
);

	logic [31:0] xs;
	logic [31:0] ys;
	logic [63:0] prod;

	// step 0: xlo*ylo, step 1: xlo*yhi<<32, step 2: xhi*ylo<<32
	always_comb begin
		xs = (step == msa_pkg::MAC_LAST) ? x[63:32] : x[31:0];
		ys = (step == 2'd1) ? y[63:32] : y[31:0];
		prod = {32'd0, xs} * {32'd0, ys};
		if (step == 2'd0) begin
			sum = prod;
		end else begin
			sum = acc + {prod[31:0], 32'd0};
		end
	end

endmodule

// File: rtl/core/modular_signed_alu.sv
// ---------------------------------------------------------------------------
// modular_signed_alu
// Two's-complement ALU at a programmable width, results wrap mod 2^width.
// ---------------------------------------------------------------------------
//  channel  | signals                         | moves
//  ---------+---------------------------------+-----------------------------
//  in       | in_valid, in_stall, in_word     | operation and two operands
//  out      | out_valid, out_stall, out_word  | value, compare_true, status
//  cfg      | psel..pready (APB)              | width register at 0x0
//
// One word at a time. Add, sub, compares, neg, abs and refused words are settled in the
// decode state; mul takes three passes of the shared 32x32 multiplier; div and rem
// take one restoring bit per cycle; pow squares once per bit of exponent and multiplies
// once per set bit, on the same multiplier. The result sits in an output
// register, so a stalled output holds the block only at its next result.
// Reset sets width to 64.
module modular_signed_alu #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msa_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output msa_pkg::out_word_t  out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [0:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int WCAP = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MUL, S_DIV, S_DIVFIN, S_POW, S_PMUL, S_PSQR, S_DONE
	} state_t;

	state_t             state_q;
	logic [6:0]         width_q;
	logic [6:0]         w_eff;
	logic [63:0]        mask;
	logic [63:0]        sbit;
	logic [3:0]         op_q;
	logic [63:0]        a_q, b_q, m_q, sbit_q;
	logic [63:0]        r_q, base_q, e_q, acc_q;
	logic [1:0]         mstep_q;
	logic [63:0]        rem_q, quo_q, mb_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	msa_pkg::out_word_t res_q;
	msa_pkg::out_word_t out_q;
	logic               out_valid_q;
	msa_pkg::out_word_t dec_res;

	logic [63:0] mac_x, mac_y, mac_sum;
	logic        sa, sb, a_bad, b_bad, unary;
	logic [63:0] ma, mb, ka, kb, shifted;
	logic        ge;

	always_comb begin
		if (width_q == 7'd0) begin
			w_eff = 7'd1;
		end else if (width_q > 7'(WCAP)) begin
			w_eff = 7'(WCAP);
		end else begin
			w_eff = width_q;
		end
		mask = (w_eff == 7'd64) ? '1 : ((64'd1 << w_eff) - 64'd1);
		sbit = 64'd1 << (w_eff - 7'd1);
	end

	always_comb begin
		sa = |(a_q & sbit_q);
		sb = |(b_q & sbit_q);
		ma = sa ? ((64'd0 - a_q) & m_q) : a_q;
		mb = sb ? ((64'd0 - b_q) & m_q) : b_q;
		ka = a_q ^ sbit_q;
		kb = b_q ^ sbit_q;
		a_bad = |(a_q & ~m_q);
		b_bad = |(b_q & ~m_q);
		unary = (op_q == msa_pkg::OP_NEG) || (op_q == msa_pkg::OP_ABS) ||
			(op_q == msa_pkg::OP_POW);
		shifted = {rem_q[62:0], quo_q[63]};
		ge = shifted >= mb_q;
	end

	// results and refusals that are settled in the decode state
	always_comb begin
		dec_res = '0;
		if (op_q <= msa_pkg::OP_POW && (a_bad || (!unary && b_bad))) begin
			dec_res.status = msa_pkg::ST_TOO_WIDE;
		end else begin
			case (op_q) inside
				msa_pkg::OP_ADD: dec_res.value = (a_q + b_q) & m_q;
				msa_pkg::OP_SUB: dec_res.value = (a_q - b_q) & m_q;
				msa_pkg::OP_NEG: dec_res.value = (64'd0 - a_q) & m_q;
				msa_pkg::OP_ABS: dec_res.value = ma;
				msa_pkg::OP_GTH: dec_res.compare_true = ka > kb;
				msa_pkg::OP_LTH: dec_res.compare_true = ka < kb;
				msa_pkg::OP_LTE: dec_res.compare_true = ka <= kb;
				msa_pkg::OP_GTE: dec_res.compare_true = ka >= kb;
				msa_pkg::OP_DIV, msa_pkg::OP_REM: begin
					if (b_q == 64'd0) begin
						dec_res.status = msa_pkg::ST_ZERO_DIV;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			S_PMUL: begin
				mac_x = r_q;
				mac_y = base_q;
			end
			S_PSQR: begin
				mac_x = base_q;
				mac_y = base_q;
			end
			default: begin
				mac_x = a_q;
				mac_y = b_q;
			end
		endcase
	end

	msa_mac u_mac (
		.x    (mac_x),
		.y    (mac_y),
		.step (mstep_q),
		.acc  (acc_q),
		.sum  (mac_sum)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == 1'b0) ? {25'd0, width_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			width_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mstep_q     <= 2'd0;
			cnt_q       <= 6'd0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_word.operation;
						a_q     <= in_word.operand_a;
						b_q     <= in_word.operand_b;
						m_q     <= mask;
						sbit_q  <= sbit;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_q   <= dec_res;
					mstep_q <= 2'd0;
					cnt_q   <= 6'd0;
					if (dec_res.status != msa_pkg::ST_OK) begin
						state_q <= S_DONE;
					end else begin
						case (op_q) inside
							msa_pkg::OP_MUL: state_q <= S_MUL;
							msa_pkg::OP_POW: begin
								r_q     <= 64'd1;
								base_q  <= a_q;
								e_q     <= b_q;
								state_q <= S_POW;
							end
							msa_pkg::OP_DIV, msa_pkg::OP_REM: begin
								mb_q    <= mb;
								rem_q   <= 64'd0;
								quo_q   <= ma;
								neg_q   <= (op_q == msa_pkg::OP_DIV) ? (sa ^ sb) : sa;
								state_q <= S_DIV;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_MUL: begin
					acc_q <= mac_sum;
					if (mstep_q == msa_pkg::MAC_LAST) begin
						res_q.value <= mac_sum & m_q;
						state_q     <= S_DONE;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				S_POW: begin
					mstep_q <= 2'd0;
					if (e_q == 64'd0) begin
						res_q.value <= r_q & m_q;
						state_q     <= S_DONE;
					end else if (e_q[0]) begin
						state_q <= S_PMUL;
					end else begin
						state_q <= S_PSQR;
					end
				end
				S_PMUL: begin
					acc_q <= mac_sum;
					if (mstep_q == msa_pkg::MAC_LAST) begin
						r_q     <= mac_sum & m_q;
						mstep_q <= 2'd0;
						state_q <= S_PSQR;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				S_PSQR: begin
					acc_q <= mac_sum;
					if (mstep_q == msa_pkg::MAC_LAST) begin
						base_q  <= mac_sum & m_q;
						e_q     <= e_q >> 1;
						state_q <= S_POW;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q <= ge ? (shifted - mb_q) : shifted;
					quo_q <= {quo_q[62:0], ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= S_DIVFIN;
					end
				end
				S_DIVFIN: begin
					if (op_q == msa_pkg::OP_DIV) begin
						res_q.value <= (neg_q ? (64'd0 - quo_q) : quo_q) & m_q;
					end else begin
						res_q.value <= (neg_q ? (64'd0 - rem_q) : rem_q) & m_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (!out_valid_q || !out_stall) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/msa_checker.sv
// ---------------------------------------------------------------------------
// msa_checker
// Port-level checks on the modular signed ALU, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input msa_pkg::out_word_t out_word
);

	logic err_word;

	assign err_word = out_valid && (out_word.status != msa_pkg::ST_OK);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	`ASSERT_SAME(a_err_zero, err_word, out_word.value == 64'd0 && !out_word.compare_true)
	`ASSERT_SAME(a_cmp_zero, out_valid && out_word.compare_true, out_word.value == 64'd0)
	`ASSERT_SAME(a_status_code, out_valid, out_word.status <= msa_pkg::ST_ZERO_DIV)

endmodule

bind modular_signed_alu msa_checker u_msa_checker (.*);

// File: verif/modular_signed_alu_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// modular_signed_alu_tb
// Self-checking bench: drives operation words through the valid/stall input,
// predicts each result at the programmed width and checks every output word
// field by field, over several width settings including 0, 1, 64 and 127.
// ---------------------------------------------------------------------------
module modular_signed_alu_tb;

	localparam logic [0:0] ADDR_WIDTH = 1'b0;
	localparam logic [3:0] OP_UNKNOWN = 4'd15;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	msa_pkg::in_word_t  in_word;
	logic               out_valid;
	logic               out_stall;
	msa_pkg::out_word_t out_word;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [0:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	msa_pkg::in_word_t  pending_words[$];
	msa_pkg::out_word_t awaited_results[$];
	logic [6:0] width_reg;
	int         fails;
	bit         gaps_on;
	int         in_gap;
	int         out_gap;

	modular_signed_alu u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	function automatic int unsigned eff_bits(logic [6:0] wr);
		int unsigned n;
		n = {25'd0, wr};
		if (n > 64) n = 64;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic logic [63:0] bits_mask(logic [6:0] wr);
		int unsigned n;
		n = eff_bits(wr);
		return (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	function automatic msa_pkg::out_word_t alu_predict(msa_pkg::in_word_t w, logic [6:0] wr);
		int unsigned n;
		logic [63:0] m, a, b, sb, ka, kb, ma, mb, q, r, base, e, acc;
		logic sa, sgb;
		bit unary;
		msa_pkg::out_word_t o;
		n = eff_bits(wr);
		m = bits_mask(wr);
		a = w.operand_a;
		b = w.operand_b;
		o = '0;
		o.status = msa_pkg::ST_OK;
		unary = (w.operation == msa_pkg::OP_NEG || w.operation == msa_pkg::OP_ABS ||
			w.operation == msa_pkg::OP_POW);
		sb = 64'd1 << (n - 1);
		ka = a ^ sb;
		kb = b ^ sb;
		sa = a[n-1];
		sgb = b[n-1];
		ma = sa ? ((-a) & m) : a;
		mb = sgb ? ((-b) & m) : b;
		if (w.operation <= msa_pkg::OP_POW &&
			((a & ~m) != 0 || (!unary && (b & ~m) != 0))) begin
			o.status = msa_pkg::ST_TOO_WIDE;
		end else begin
			case (w.operation) inside
				msa_pkg::OP_ADD: o.value = (a + b) & m;
				msa_pkg::OP_SUB: o.value = (a - b) & m;
				msa_pkg::OP_MUL: o.value = (a * b) & m;
				msa_pkg::OP_DIV, msa_pkg::OP_REM: begin
					if (b == 0) begin
						o.status = msa_pkg::ST_ZERO_DIV;
					end else if (w.operation == msa_pkg::OP_DIV) begin
						q = ma / mb;
						if (sa ^ sgb) q = -q;
						o.value = q & m;
					end else begin
						r = ma % mb;
						if (sa) r = -r;
						o.value = r & m;
					end
				end
				msa_pkg::OP_GTH: o.compare_true = ka > kb;
				msa_pkg::OP_LTH: o.compare_true = ka < kb;
				msa_pkg::OP_LTE: o.compare_true = ka <= kb;
				msa_pkg::OP_GTE: o.compare_true = ka >= kb;
				msa_pkg::OP_NEG: o.value = (-a) & m;
				msa_pkg::OP_ABS: o.value = ma & m;
				msa_pkg::OP_POW: begin
					acc = 64'd1 & m;
					base = a & m;
					e = b;
					while (e != 0) begin
						if (e[0]) acc = (acc * base) & m;
						base = (base * base) & m;
						e = e >> 1;
					end
					o.value = acc;
				end
				default: ;
			endcase
		end
		return o;
	endfunction

	// Sender: hold the word while stalled, advance on accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) awaited_results.push_back(alu_predict(in_word, width_reg));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_word <= pending_words.pop_front();
					if (gaps_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts, check each accepted word.
	always @(posedge clk or negedge arst_n) begin
		msa_pkg::out_word_t exp_w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result word expected none actual %h", $time, out_word);
					fails++;
				end else begin
					exp_w = awaited_results.pop_front();
					if (out_word.value !== exp_w.value) begin
						$display("%0t: value expected %h actual %h", $time, exp_w.value,
							out_word.value);
						fails++;
					end
					if (out_word.compare_true !== exp_w.compare_true) begin
						$display("%0t: compare_true expected %b actual %b", $time,
							exp_w.compare_true, out_word.compare_true);
						fails++;
					end
					if (out_word.status !== exp_w.status) begin
						$display("%0t: status expected %0d actual %0d", $time, exp_w.status,
							out_word.status);
						fails++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_gap = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_width(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WIDTH;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		width_reg = v[6:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain;
		while (pending_words.size() > 0 || in_valid || awaited_results.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic push_word(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		msa_pkg::in_word_t w;
		w.operation = op;
		w.operand_a = a;
		w.operand_b = b;
		pending_words.push_back(w);
	endtask

	function automatic logic [63:0] pick_operand(logic [63:0] m, int unsigned n);
		logic [63:0] sb;
		sb = 64'd1 << (n - 1);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return 64'd1 & m;
			2: return m;
			3: return sb;
			4: return sb - 64'd1;
			5: return {$urandom, $urandom} & (m >> $urandom_range(0, n - 1));
			default: return {$urandom, $urandom} & m;
		endcase
	endfunction

	task automatic random_words(int count);
		logic [63:0] m, a, b;
		logic [3:0] op;
		int unsigned n;
		m = bits_mask(width_reg);
		n = eff_bits(width_reg);
		repeat (count) begin
			op = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(12, 15))
				: 4'($urandom_range(0, 11));
			a = pick_operand(m, n);
			b = pick_operand(m, n);
			if (op == msa_pkg::OP_POW)
				b = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : $urandom_range(0, 40);
			if ((op == msa_pkg::OP_DIV || op == msa_pkg::OP_REM) && b == 0 &&
				$urandom_range(0, 3) != 0)
				b = 64'd1;
			// drop a stray high bit in now and then
			if (n < 64 && $urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 1)) a = a | (64'd1 << $urandom_range(n, 63));
				else b = b | (64'd1 << $urandom_range(n, 63));
			end
			push_word(op, a, b);
		end
	endtask

	initial begin
		int widths[9];
		logic [63:0] mn;
		widths = '{8, 1, 0, 127, 33, 2, 100, 16, 63};
		fails = 0;
		gaps_on = 1'b1;
		width_reg = 7'd64;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset width of 64
		mn = 64'h8000_0000_0000_0000;
		push_word(msa_pkg::OP_ADD, '1, 64'd1);
		push_word(msa_pkg::OP_ADD, mn - 1, 64'd1);
		push_word(msa_pkg::OP_SUB, 64'd0, 64'd1);
		push_word(msa_pkg::OP_MUL, '1, '1);
		push_word(msa_pkg::OP_DIV, mn, '1);
		push_word(msa_pkg::OP_REM, mn, '1);
		push_word(msa_pkg::OP_DIV, 64'd7, 64'd0);
		push_word(msa_pkg::OP_REM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
		push_word(msa_pkg::OP_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
		push_word(msa_pkg::OP_GTH, mn, mn - 1);
		push_word(msa_pkg::OP_LTH, mn, mn - 1);
		push_word(msa_pkg::OP_LTE, 64'd5, 64'd5);
		push_word(msa_pkg::OP_GTE, '1, 64'd0);
		push_word(msa_pkg::OP_NEG, 64'd0, '1);
		push_word(msa_pkg::OP_NEG, mn, 64'd0);
		push_word(msa_pkg::OP_ABS, mn, 64'd0);
		push_word(msa_pkg::OP_ABS, '1, 64'd0);
		push_word(msa_pkg::OP_POW, 64'd0, 64'd0);
		push_word(msa_pkg::OP_POW, 64'd3, '1);
		push_word(OP_UNKNOWN, '1, '1);
		drain();

		// directed words at a width of 8, some with operands wider than it
		write_width(32'd8);
		push_word(msa_pkg::OP_ADD, 64'h100, 64'd1);
		push_word(msa_pkg::OP_DIV, 64'h1FF, 64'd0);
		push_word(msa_pkg::OP_NEG, 64'h80, 64'hFFFF);
		push_word(msa_pkg::OP_POW, 64'h3, 64'hFFFF_0000_0000_0000);
		drain();

		foreach (widths[i]) begin
			write_width(widths[i]);
			random_words(140);
			drain();
		end

		write_width(32'd64);
		gaps_on = 1'b0;
		random_words(170);
		drain();

		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
